/* hdl/tft_pkg.sv */
// tft_pkg: shared types and constants for the trickle flood timer core.
// Holds payload structs, request and register codes, phase and controller states.
// No dependencies.
`timescale 1ns / 1ps

package tft_pkg;

  localparam int SEQ_W  = 16;
  localparam int RAND_W = 16;
  localparam int DBL_W  = 4;
  localparam int DUP_W  = 8;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_RX    = 2'd1;
  localparam logic [1:0] REQ_LOCAL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_INTERVAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DOUBLINGS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUPLICATE_LIMIT = 2'd2;

  localparam logic [CFG_W-1:0] BASE_INTERVAL_RST   = 16'd128;
  localparam logic [DBL_W-1:0] MAX_DOUBLINGS_RST   = 4'd4;
  localparam logic [DUP_W-1:0] DUPLICATE_LIMIT_RST = 8'd1;
  localparam logic [DUP_W-1:0] DUP_MAX             = 8'd255;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SEQ_W-1:0]  rx_seqno;
    logic [RAND_W-1:0] rand_value;
  } tft_req_t;

  typedef struct packed {
    logic [1:0]       transmit_count;
    logic             deliver_up;
    logic [SEQ_W-1:0] current_seqno;
    logic [DBL_W-1:0] doubling_now;
  } tft_rsp_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LISTEN,
    PH_WAIT
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FS_GO,
    S_FS_RUN,
    S_LI_GO,
    S_LI_RUN,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic idle;
    logic load_in;
    logic decode;
    logic fs_go;
    logic fs_load;
    logic li_go;
    logic li_load;
    logic out_load;
  } tft_cmd_t;

  typedef struct packed {
    logic need_fs;
    logic need_start;
    logic mod_busy;
    logic mod_done;
    logic out_free;
  } tft_stat_t;

endpackage

/* hdl/tft_mod.sv */
// tft_mod: iterative restoring remainder unit, one dividend bit per cycle.
// Returns 0 for a zero divisor. Uses tft_pkg.
`timescale 1ns / 1ps

module tft_mod #(
  parameter int DIV_W = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tft_pkg::RAND_W-1:0] dividend,
  input  logic [DIV_W-1:0]           divisor,
  output logic                       busy,
  output logic                       done,
  output logic [tft_pkg::RAND_W-1:0] remainder
);
  import tft_pkg::*;

  localparam int CNT_W = $clog2(RAND_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [RAND_W-1:0] dvd;
  logic [RAND_W-1:0] rem;
  logic [DIV_W-1:0]  dsr;
  logic              zdiv;
  logic [RAND_W:0]   trial;
  logic [DIV_W-1:0]  trial_ext;
  logic [DIV_W-1:0]  diff;

  always_comb begin
    trial     = {rem, dvd[RAND_W-1]};
    trial_ext = DIV_W'(trial);
    diff      = trial_ext - dsr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(RAND_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      rem  <= '0;
      dsr  <= divisor;
      zdiv <= (divisor == '0);
    end else if (cnt != '0) begin
      dvd <= {dvd[RAND_W-2:0], 1'b0};
      if (trial_ext >= dsr) begin
        rem <= diff[RAND_W-1:0];
      end else begin
        rem <= trial[RAND_W-1:0];
      end
    end
  end

  assign busy      = (cnt != '0);
  assign remainder = zdiv ? '0 : rem;

endmodule

/* hdl/tft_datapath.sv */
// tft_datapath: configuration, flood state, countdown timers and output register.
// Executes controller commands; instantiates tft_mod. Uses tft_pkg.
`timescale 1ns / 1ps

module tft_datapath #(
  parameter int TIMER_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tft_pkg::CFG_W-1:0]     cfg_data,
  input  tft_pkg::tft_req_t             req,
  input  logic                          rsp_stall,
  output logic                          rsp_valid,
  output tft_pkg::tft_rsp_t             rsp,
  input  tft_pkg::tft_cmd_t             cmd,
  output tft_pkg::tft_stat_t            stat
);
  import tft_pkg::*;

  localparam int EXT_W = TIMER_BITS + CFG_W;

  logic [CFG_W-1:0] base_interval;
  logic [DBL_W-1:0] max_doublings;
  logic [DUP_W-1:0] duplicate_limit;

  tft_req_t        item;
  phase_t          phase, phase_next;
  logic [SEQ_W-1:0] held_seqno, held_seqno_next;
  logic [DBL_W-1:0] doubling_count, doubling_count_next;
  logic [DUP_W-1:0] duplicate_count, duplicate_count_next;
  logic             data_held, data_held_next;
  logic [TIMER_BITS-1:0] interval_left, interval_left_next;
  logic [TIMER_BITS-1:0] listen_left, listen_left_next;
  logic [TIMER_BITS-1:0] first_send_left, first_send_left_next;
  logic             first_send_armed, first_send_armed_next;
  logic [1:0]       sends, sends_next;
  logic             deliver, deliver_next;
  logic             need_start, need_start_next;
  logic             need_fs, need_fs_next;
  logic             rsp_valid_next;

  logic [EXT_W-1:0]      len_ext;
  logic [TIMER_BITS-1:0] len;
  logic [TIMER_BITS-1:0] half;
  logic [SEQ_W-1:0]      diff;
  logic                  mod_busy;
  logic                  mod_done;
  logic [RAND_W-1:0]     mod_rem;
  logic [TIMER_BITS-1:0] mod_divisor;

  always_comb begin
    len_ext = EXT_W'(base_interval) << doubling_count;
    if (|len_ext[EXT_W-1:TIMER_BITS]) begin
      len = '1;
    end else begin
      len = len_ext[TIMER_BITS-1:0];
    end
    half = len >> 1;
    diff = item.rx_seqno - held_seqno;
    mod_divisor = cmd.li_go ? half : TIMER_BITS'(base_interval);
  end

  tft_mod #(
    .DIV_W(TIMER_BITS)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.fs_go | cmd.li_go),
    .dividend  (item.rand_value),
    .divisor   (mod_divisor),
    .busy      (mod_busy),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_comb begin
    logic   fs;
    logic   li;
    logic   iv;
    logic   snd_a;
    logic   snd_b;
    phase_t ph;

    phase_next            = phase;
    held_seqno_next       = held_seqno;
    doubling_count_next   = doubling_count;
    duplicate_count_next  = duplicate_count;
    data_held_next        = data_held;
    interval_left_next    = interval_left;
    listen_left_next      = listen_left;
    first_send_left_next  = first_send_left;
    first_send_armed_next = first_send_armed;
    sends_next            = sends;
    deliver_next          = deliver;
    need_start_next       = need_start;
    need_fs_next          = need_fs;
    fs    = 1'b0;
    li    = 1'b0;
    iv    = 1'b0;
    snd_a = 1'b0;
    snd_b = 1'b0;
    ph    = phase;

    if (cmd.decode) begin
      sends_next      = 2'd0;
      deliver_next    = 1'b0;
      need_start_next = 1'b0;
      need_fs_next    = 1'b0;
      case (item.req_type)
        REQ_TICK: begin
          if (first_send_armed) begin
            fs = (first_send_left <= TIMER_BITS'(1));
            first_send_left_next = fs ? '0 : first_send_left - TIMER_BITS'(1);
          end
          if (phase == PH_LISTEN) begin
            li = (listen_left <= TIMER_BITS'(1));
            listen_left_next = li ? '0 : listen_left - TIMER_BITS'(1);
          end
          if (phase != PH_IDLE) begin
            iv = (interval_left <= TIMER_BITS'(1));
            interval_left_next = iv ? '0 : interval_left - TIMER_BITS'(1);
          end
          first_send_armed_next = first_send_armed & ~fs;
          snd_a = fs & data_held;
          if (li) begin
            snd_b = (duplicate_count < duplicate_limit) & data_held;
            ph    = PH_WAIT;
          end
          if (iv) begin
            case (ph)
              PH_LISTEN: begin
                snd_b = (duplicate_count < duplicate_limit) & data_held;
                ph    = PH_WAIT;
              end
              PH_WAIT: begin
                if (doubling_count < max_doublings) begin
                  doubling_count_next = doubling_count + DBL_W'(1);
                end
                need_start_next = 1'b1;
              end
              default: begin
              end
            endcase
          end
          phase_next = ph;
          sends_next = {1'b0, snd_a} + {1'b0, snd_b};
        end
        REQ_RX: begin
          if (diff == '0) begin
            if (duplicate_count < DUP_MAX) begin
              duplicate_count_next = duplicate_count + DUP_W'(1);
            end
          end else if (diff[SEQ_W-1]) begin
            doubling_count_next = '0;
            sends_next          = {1'b0, data_held};
          end else begin
            held_seqno_next     = item.rx_seqno;
            data_held_next      = 1'b1;
            doubling_count_next = '0;
            deliver_next        = 1'b1;
            need_start_next     = 1'b1;
            need_fs_next        = 1'b1;
          end
        end
        REQ_LOCAL: begin
          held_seqno_next     = held_seqno + SEQ_W'(1);
          data_held_next      = 1'b1;
          doubling_count_next = '0;
          need_start_next     = 1'b1;
          sends_next          = 2'd1;
        end
        default: begin
        end
      endcase
    end

    if (cmd.fs_load) begin
      first_send_left_next  = TIMER_BITS'(mod_rem);
      first_send_armed_next = 1'b1;
    end

    if (cmd.li_load) begin
      interval_left_next   = len;
      listen_left_next     = half + TIMER_BITS'(mod_rem);
      duplicate_count_next = '0;
      phase_next           = PH_LISTEN;
    end
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.out_load) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_interval    <= BASE_INTERVAL_RST;
      max_doublings    <= MAX_DOUBLINGS_RST;
      duplicate_limit  <= DUPLICATE_LIMIT_RST;
      phase            <= PH_IDLE;
      held_seqno       <= '0;
      doubling_count   <= '0;
      duplicate_count  <= '0;
      data_held        <= 1'b0;
      interval_left    <= '0;
      listen_left      <= '0;
      first_send_left  <= '0;
      first_send_armed <= 1'b0;
      sends            <= '0;
      deliver          <= 1'b0;
      need_start       <= 1'b0;
      need_fs          <= 1'b0;
      rsp_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_INTERVAL:   base_interval   <= cfg_data;
          CFG_MAX_DOUBLINGS:   max_doublings   <= cfg_data[DBL_W-1:0];
          CFG_DUPLICATE_LIMIT: duplicate_limit <= cfg_data[DUP_W-1:0];
          default: begin
          end
        endcase
      end
      phase            <= phase_next;
      held_seqno       <= held_seqno_next;
      doubling_count   <= doubling_count_next;
      duplicate_count  <= duplicate_count_next;
      data_held        <= data_held_next;
      interval_left    <= interval_left_next;
      listen_left      <= listen_left_next;
      first_send_left  <= first_send_left_next;
      first_send_armed <= first_send_armed_next;
      sends            <= sends_next;
      deliver          <= deliver_next;
      need_start       <= need_start_next;
      need_fs          <= need_fs_next;
      rsp_valid        <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item <= req;
    end
    if (cmd.out_load) begin
      rsp.transmit_count <= sends;
      rsp.deliver_up     <= deliver;
      rsp.current_seqno  <= held_seqno;
      rsp.doubling_now   <= doubling_count;
    end
  end

  assign stat.need_fs    = need_fs;
  assign stat.need_start = need_start;
  assign stat.mod_busy   = mod_busy;
  assign stat.mod_done   = mod_done;
  assign stat.out_free   = ~rsp_valid | ~rsp_stall;

endmodule

/* hdl/tft_ctrl.sv */
// tft_ctrl: sequencing state machine for the trickle flood timer core.
// Drives datapath commands from datapath status. Uses tft_pkg.
`timescale 1ns / 1ps

module tft_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  tft_pkg::tft_stat_t  stat,
  output tft_pkg::tft_cmd_t   cmd
);
  import tft_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_FS_GO;
      end
      S_FS_GO: begin
        if (stat.need_fs) begin
          cmd.fs_go  = 1'b1;
          state_next = S_FS_RUN;
        end else begin
          state_next = S_LI_GO;
        end
      end
      S_FS_RUN: begin
        if (stat.mod_done) begin
          cmd.fs_load = 1'b1;
          state_next  = S_LI_GO;
        end
      end
      S_LI_GO: begin
        if (stat.need_start) begin
          cmd.li_go  = 1'b1;
          state_next = S_LI_RUN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LI_RUN: begin
        if (stat.mod_done) begin
          cmd.li_load = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/trickle_flood_timer_core.sv */
// trickle_flood_timer_core: top level of the Trickle single-source flood controller.
// Joins tft_ctrl and tft_datapath; uses tft_pkg.
//
// Each accepted transaction (tick, received packet or local new data) yields one
// result transaction. The core handles one transaction at a time. A transaction
// that starts no interval needs no draw from the shared remainder unit, one that
// starts an interval needs one, and a newer received packet needs two: the
// first-send delay and the listen offset. The remainder unit takes one bit of
// the 16-bit random word per cycle. The result register lets a new transaction
// be accepted while the previous result is still stalled.
`timescale 1ns / 1ps

module trickle_flood_timer_core #(
  parameter int TIMER_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tft_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  tft_pkg::tft_req_t             req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output tft_pkg::tft_rsp_t             rsp
);
  import tft_pkg::*;

  tft_cmd_t  cmd;
  tft_stat_t stat;

  tft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  tft_datapath #(
    .TIMER_BITS(TIMER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign req_stall = ~cmd.idle;

  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("accepted a transaction while another is in flight");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.fs_go || cmd.li_go) |-> !stat.mod_busy)
    else $error("remainder unit restarted while busy");

  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten while stalled");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.deliver_up) |-> (rsp.transmit_count == 2'd0))
    else $error("adopted data reported with a broadcast");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.transmit_count != 2'd3))
    else $error("broadcast count out of range");

endmodule

/* tb/sv/tb_top.sv */
// tb_top: self-checking testbench for trickle_flood_timer_core.
// Predicts each result transaction from its own model of the flood controller.
// Depends on tft_pkg and trickle_flood_timer_core.
`timescale 1ns / 1ps

module tb_top;
  import tft_pkg::*;

  localparam int TIMER_BITS = 32;
  localparam logic [63:0] TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  tft_req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  tft_rsp_t rsp;

  trickle_flood_timer_core #(.TIMER_BITS(TIMER_BITS)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // controller copy: registers and state
  logic [15:0] base_ivl = BASE_INTERVAL_RST;
  logic [3:0] max_dbl = MAX_DOUBLINGS_RST;
  logic [7:0] dup_lim = DUPLICATE_LIMIT_RST;
  phase_t ph = PH_IDLE;
  logic [15:0] seq_q = '0;
  logic [3:0] dbl_q = '0;
  logic [7:0] dup_q = '0;
  logic have_data = 1'b0;
  logic [63:0] ivl_left = '0;
  logic [63:0] lst_left = '0;
  logic [63:0] fs_left = '0;
  logic fs_armed = 1'b0;
  int unsigned sends;

  tft_rsp_t pending_reports[$];
  tft_rsp_t want;
  int n_errors = 0;
  int n_items = 0;
  int n_settings = 0;
  int n_broadcasts = 0;
  int n_delivered = 0;
  int gap_pct = 25;
  bit calm = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  function automatic void note_send();
    if (have_data && sends < 3) sends++;
  endfunction

  function automatic void open_interval(input logic [15:0] rnd);
    logic [63:0] len;
    logic [63:0] half;
    len = {48'd0, base_ivl} << dbl_q;
    if (len > TIMER_MAX) len = TIMER_MAX;
    half = len >> 1;
    ivl_left = len;
    lst_left = half + ((half != 0) ? ({48'd0, rnd} % half) : 64'd0);
    dup_q = '0;
    ph = PH_LISTEN;
  endfunction

  function automatic void next_stage(input logic [15:0] rnd);
    if (ph == PH_LISTEN) begin
      if (dup_q < dup_lim) note_send();
      ph = PH_WAIT;
    end else if (ph == PH_WAIT) begin
      if (dbl_q < max_dbl) dbl_q++;
      open_interval(rnd);
    end
  endfunction

  function automatic tft_rsp_t predict_flood(input tft_req_t item);
    logic fs_fire;
    logic li_fire;
    logic iv_fire;
    logic fresh;
    logic [15:0] diff;
    tft_rsp_t r;
    sends = 0;
    fresh = 1'b0;
    fs_fire = 1'b0;
    li_fire = 1'b0;
    iv_fire = 1'b0;
    case (item.req_type)
      REQ_TICK: begin
        // expiries come from the values held before this tick
        if (fs_armed) begin
          fs_fire = (fs_left <= 1);
          fs_left = fs_fire ? 64'd0 : fs_left - 1;
        end
        if (ph == PH_LISTEN) begin
          li_fire = (lst_left <= 1);
          lst_left = li_fire ? 64'd0 : lst_left - 1;
        end
        if (ph != PH_IDLE) begin
          iv_fire = (ivl_left <= 1);
          ivl_left = iv_fire ? 64'd0 : ivl_left - 1;
        end
        if (fs_fire) begin
          fs_armed = 1'b0;
          note_send();
        end
        if (li_fire) next_stage(item.rand_value);
        if (iv_fire) next_stage(item.rand_value);
      end
      REQ_RX: begin
        diff = item.rx_seqno - seq_q;
        if (diff == 16'd0) begin
          if (dup_q != DUP_MAX) dup_q++;
        end else if (diff[15]) begin
          dbl_q = '0;
          note_send();
        end else begin
          seq_q = item.rx_seqno;
          have_data = 1'b1;
          dbl_q = '0;
          open_interval(item.rand_value);
          fs_left = (base_ivl != 0) ? ({48'd0, item.rand_value} % {48'd0, base_ivl}) : 64'd0;
          fs_armed = 1'b1;
          fresh = 1'b1;
        end
      end
      REQ_LOCAL: begin
        seq_q = seq_q + 16'd1;
        have_data = 1'b1;
        dbl_q = '0;
        open_interval(item.rand_value);
        note_send();
      end
      default: begin
      end
    endcase
    r.transmit_count = (sends > 3) ? 2'd3 : sends[1:0];
    r.deliver_up = fresh;
    r.current_seqno = seq_q;
    r.doubling_now = dbl_q;
    return r;
  endfunction

  function automatic tft_req_t make_item(input logic [1:0] kind, input logic [15:0] rx,
                                         input logic [15:0] rnd);
    tft_req_t r;
    r.req_type = kind;
    r.rx_seqno = rx;
    r.rand_value = rnd;
    return r;
  endfunction

  function automatic tft_req_t random_item(input int tick_pct);
    tft_req_t r;
    r.rx_seqno = $urandom_range(0, 65535);
    r.rand_value = $urandom_range(0, 65535);
    r.req_type = REQ_TICK;
    if ($urandom_range(0, 99) >= tick_pct) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          r.req_type = REQ_RX;
          r.rx_seqno = seq_q;
        end
        2, 3: begin
          r.req_type = REQ_RX;
          r.rx_seqno = seq_q - 16'($urandom_range(1, 32768));
        end
        4, 5: begin
          r.req_type = REQ_RX;
          r.rx_seqno = seq_q + 16'($urandom_range(1, 32767));
        end
        6: r.req_type = REQ_RX;
        7, 8: r.req_type = REQ_LOCAL;
        default: r.req_type = REQ_UNUSED;
      endcase
    end
    return r;
  endfunction

  function automatic void check_field(input string what, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
      n_errors++;
    end
  endfunction

  task automatic send_item(input tft_req_t item);
    tft_rsp_t p;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    p = predict_flood(item);
    pending_reports.push_back(p);
    n_items++;
    n_broadcasts += p.transmit_count;
    n_delivered += p.deliver_up;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until every result is back, then load all three registers
  task automatic set_cfg(input logic [15:0] b, input logic [3:0] m, input logic [7:0] d);
    req_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(CFG_BASE_INTERVAL, b);
    write_reg(CFG_MAX_DOUBLINGS, {12'd0, m});
    write_reg(CFG_DUPLICATE_LIMIT, {8'd0, d});
    base_ivl = b;
    max_dbl = m;
    dup_lim = d;
    n_settings++;
  endtask

  task automatic test_startup_packets();
    send_item(make_item(REQ_TICK, 16'hFFFF, 16'hFFFF));
    send_item(make_item(REQ_UNUSED, 16'h5A5A, 16'hA5A5));
    send_item(make_item(REQ_RX, 16'h0000, 16'h0000));
    send_item(make_item(REQ_RX, 16'h8000, 16'h1234));
    send_item(make_item(REQ_LOCAL, 16'h0000, 16'hFFFF));
    send_item(make_item(REQ_RX, 16'h0001, 16'h0000));
    send_item(make_item(REQ_RX, 16'h8001, 16'h0000));
    send_item(make_item(REQ_RX, 16'h8000, 16'h0000));
    send_item(make_item(REQ_RX, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_short_intervals();
    set_cfg(16'd1, 4'd0, 8'd0);
    send_item(make_item(REQ_LOCAL, 16'h0000, 16'h7FFF));
    repeat (3) send_item(make_item(REQ_TICK, 16'h0000, 16'h0003));
    set_cfg(16'd2, 4'd15, 8'd255);
    send_item(make_item(REQ_RX, seq_q + 16'd1, 16'd1));
    repeat (4) send_item(make_item(REQ_TICK, 16'h0000, 16'hFFFF));
  endtask

  task automatic test_zero_base();
    set_cfg(16'd0, 4'd15, 8'd255);
    send_item(make_item(REQ_RX, seq_q + 16'h7FFF, 16'hFFFF));
    send_item(make_item(REQ_TICK, 16'h0000, 16'h0000));
    send_item(make_item(REQ_LOCAL, 16'h0000, 16'h8000));
    send_item(make_item(REQ_TICK, 16'h0000, 16'h0001));
  endtask

  task automatic test_random_sweep();
    int p;
    int k;
    int tick_pct;
    logic [15:0] b;
    logic [3:0] m;
    logic [7:0] d;
    for (p = 0; p < 14; p++) begin
      case (p)
        0: begin
          b = 16'hFFFF; m = 4'hF; d = 8'hFF; tick_pct = 70;
        end
        1: begin
          b = 16'd1; m = 4'd0; d = 8'd0; tick_pct = 80;
        end
        2: begin
          b = 16'd0; m = 4'd5; d = 8'd1; tick_pct = 80;
        end
        default: begin
          b = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(5, 40))
                                          : 16'($urandom_range(1, 4));
          m = ($urandom_range(0, 4) == 0) ? 4'hF : 4'($urandom_range(0, 4));
          d = ($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom_range(0, 3));
          tick_pct = $urandom_range(75, 95);
        end
      endcase
      calm = (p >= 12);
      gap_pct = (calm || p % 3 == 0) ? 0 : 25;
      set_cfg(b, m, d);
      for (k = 0; k < 100; k++) send_item(random_item(tick_pct));
    end
  endtask

  task automatic finish_run();
    req_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d transactions over %0d register settings,", n_items, n_settings);
    $display("with %0d broadcasts and %0d deliveries predicted.", n_broadcasts, n_delivered);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_startup_packets();
    test_short_intervals();
    test_zero_base();
    test_random_sweep();
    finish_run();
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (rsp_stall) begin
      rsp_stall <= 1'b0;
      stall_left <= $urandom_range(0, 40);
    end else if ($urandom_range(0, 3) == 0) begin
      rsp_stall <= 1'b1;
      stall_left <= $urandom_range(0, 17);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result transaction with none expected, actual %h", $time, rsp);
        n_errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("transmit_count", want.transmit_count, rsp.transmit_count);
        check_field("deliver_up", want.deliver_up, rsp.deliver_up);
        check_field("current_seqno", want.current_seqno, rsp.current_seqno);
        check_field("doubling_now", want.doubling_now, rsp.doubling_now);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

endmodule

/* trickle_flood_timer_core.f */
hdl/tft_pkg.sv
hdl/tft_mod.sv
hdl/tft_datapath.sv
hdl/tft_ctrl.sv
hdl/trickle_flood_timer_core.sv
tb/sv/tb_top.sv
